>>> rtl/dmpm_pkg.sv
// Shared types, constants and helper functions for the drive mixer and pulse mapper.
// This package stands alone; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package dmpm_pkg;

   localparam int NUM_WHEELS  = 4;
   localparam int AXIS_W      = 8;
   localparam int PULSE_W     = 12;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   // Product of an 8-bit offset and a 12-bit span, and the reciprocal product.
   localparam int PROD_W  = AXIS_W + PULSE_W;
   localparam int RECIP_W = 41;
   // floor(m / 255) == (m * (2^20 + 2^12 + 2^4 + 1)) >> 28 for every m below 2^20.
   localparam int RECIP_SHIFT = 28;

   // Drive modes.
   localparam logic [MODE_W-1:0] MODE_TANK      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARCADE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HOLONOMIC = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_MASK = 2'd3;

   // Wheel indexes, matching the reverse mask bits.
   localparam int WHEEL_FL = 0;
   localparam int WHEEL_BL = 1;
   localparam int WHEEL_FR = 2;
   localparam int WHEEL_BR = 3;

   typedef logic signed [AXIS_W-1:0]  wheel_type;
   typedef wheel_type [NUM_WHEELS-1:0] wheel_vec_type;
   typedef logic [PULSE_W-1:0]         pulse_type;

   localparam wheel_type WHEEL_MIN = 8'sh80;
   localparam wheel_type WHEEL_MAX = 8'sh7f;

   localparam pulse_type MIN_PULSE_RESET = 12'd1000;
   localparam pulse_type MAX_PULSE_RESET = 12'd2000;

   typedef struct packed {
      pulse_type min_pulse;
      pulse_type max_pulse;
   } pulse_cfg_type;

   // Clamp a mixed sum (at most three axes) to the signed 8-bit wheel range.
   function automatic wheel_type sat_wheel(input logic signed [AXIS_W+1:0] x);
      logic signed [AXIS_W+1:0] lo;
      logic signed [AXIS_W+1:0] hi;
      lo = {{2{WHEEL_MIN[AXIS_W-1]}}, WHEEL_MIN};
      hi = {{2{WHEEL_MAX[AXIS_W-1]}}, WHEEL_MAX};
      if (x < lo) begin
         sat_wheel = WHEEL_MIN;
      end else if (x > hi) begin
         sat_wheel = WHEEL_MAX;
      end else begin
         sat_wheel = x[AXIS_W-1:0];
      end
   endfunction

   // Negate a wheel value; full negative drive turns into full positive drive.
   function automatic wheel_type neg_wheel(input wheel_type v);
      if (v == WHEEL_MIN) begin
         neg_wheel = WHEEL_MAX;
      end else begin
         neg_wheel = -v;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/dmpm_mixer.sv
// Combinational axis mixer: turns three stick axes into four saturated wheel values.
// Depends on dmpm_pkg for the wheel types, mode codes and saturation function.
`timescale 1ns / 1ps
`default_nettype none

module dmpm_mixer
   import dmpm_pkg::*;
(
   input  wire logic [MODE_W-1:0] drive_mode,
   input  wire wheel_type         forward_or_left,
   input  wire wheel_type         yaw_or_right,
   input  wire wheel_type         strafe_axis,
   output wheel_vec_type          wheels
);

   logic signed [AXIS_W+1:0] f_x;
   logic signed [AXIS_W+1:0] y_x;
   logic signed [AXIS_W+1:0] s_x;

   assign f_x = {{2{forward_or_left[AXIS_W-1]}}, forward_or_left};
   assign y_x = {{2{yaw_or_right[AXIS_W-1]}}, yaw_or_right};
   assign s_x = {{2{strafe_axis[AXIS_W-1]}}, strafe_axis};

   always_comb begin
      unique case (drive_mode)
         MODE_ARCADE: begin
            wheels[WHEEL_FL] = sat_wheel(f_x - y_x);
            wheels[WHEEL_BL] = sat_wheel(f_x - y_x);
            wheels[WHEEL_FR] = sat_wheel(f_x + y_x);
            wheels[WHEEL_BR] = sat_wheel(f_x + y_x);
         end
         MODE_HOLONOMIC: begin
            wheels[WHEEL_FL] = sat_wheel(f_x - y_x - s_x);
            wheels[WHEEL_BL] = sat_wheel(f_x - y_x + s_x);
            wheels[WHEEL_FR] = sat_wheel(f_x + y_x + s_x);
            wheels[WHEEL_BR] = sat_wheel(f_x + y_x - s_x);
         end
         default: begin
            // Tank mode, and the unused mode code, which behaves as tank.
            wheels[WHEEL_FL] = forward_or_left;
            wheels[WHEEL_BL] = forward_or_left;
            wheels[WHEEL_FR] = yaw_or_right;
            wheels[WHEEL_BR] = yaw_or_right;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/dmpm_scale.sv
// One wheel's pulse mapper: optional reversal, span multiply, register, divide by 255.
// Depends on dmpm_pkg for the wheel and pulse types and the reciprocal constants.
`timescale 1ns / 1ps
`default_nettype none

module dmpm_scale
   import dmpm_pkg::*;
(
   input  wire logic          clock,
   input  wire wheel_type     wheel,
   input  wire logic          reverse,
   input  wire pulse_cfg_type cfg,
   output pulse_type          pulse
);

   wheel_type                 wheel_rev;
   logic [AXIS_W-1:0]         offset;
   logic signed [PULSE_W:0]   span;
   logic [PULSE_W:0]          span_neg;
   logic [PULSE_W-1:0]        span_mag;

   logic [PROD_W-1:0]         prod_in;
   logic [PROD_W-1:0]         prod_ff;
   logic                      neg_in;
   logic                      neg_ff;
   logic                      zero_in;
   logic                      zero_ff;

   logic [RECIP_W-1:0]        prod_x;
   logic [RECIP_W-1:0]        recip_sum;
   logic [PULSE_W-1:0]        quot;
   logic [PULSE_W:0]          quot_signed;
   logic [PULSE_W:0]          lin_sum;
   logic [PULSE_W:0]          mid_sum;

   // First stage: the wheel value offset to 0..255 times the magnitude of the span.
   always_comb begin
      wheel_rev = reverse ? neg_wheel(wheel) : wheel;
      offset    = {~wheel_rev[AXIS_W-1], wheel_rev[AXIS_W-2:0]};
      span      = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
      span_neg  = -span;
      span_mag  = span[PULSE_W] ? span_neg[PULSE_W-1:0] : span[PULSE_W-1:0];
      prod_in   = offset * span_mag;
      neg_in    = span[PULSE_W];
      zero_in   = (wheel_rev == '0);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // Second stage: exact division by 255 through a shift-and-add reciprocal, then the
   // truncated quotient is applied toward max_pulse from min_pulse; a zero wheel value gives the midpoint of the two.
   always_comb begin
      prod_x      = {{(RECIP_W-PROD_W){1'b0}}, prod_ff};
      recip_sum   = (prod_x << 20) + (prod_x << 12) + (prod_x << 4) + prod_x;
      quot        = recip_sum[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
      quot_signed = neg_ff ? -{1'b0, quot} : {1'b0, quot};
      lin_sum     = {1'b0, cfg.min_pulse} + quot_signed;
      mid_sum     = {1'b0, cfg.min_pulse} + {1'b0, cfg.max_pulse};
      pulse       = zero_ff ? mid_sum[PULSE_W:1] : lin_sum[PULSE_W-1:0];
   end

endmodule

`default_nettype wire

>>> rtl/drive_mixer_pulse_mapper.sv
// Top level of the drive mixer and servo pulse mapper: configuration registers,
// input register, mixer, four wheel scalers and the result register.
// Depends on dmpm_pkg, dmpm_mixer and dmpm_scale.
//
//   Channel    Ports                                   Transfer rule
//   ---------  --------------------------------------  ----------------------------------
//   request    start, busy, req_*                      taken at an edge with start high
//                                                      and busy low
//   response   rsp_valid, rsp_*_pulse                  one-cycle strobe, always taken
//   csr        csr_write_enable, csr_index,            written at an edge with
//              csr_write_data                          csr_write_enable high
//
// A transaction is taken on every clock edge at which start is high; busy is always low.
// Each result strobes rsp_valid once it has passed the input register, then the multiply
// stage register in each wheel scaler after the mix and span multiply, then the result
// register after the divide by 255. Synchronous reset clears the valid pipeline and
// restores the register defaults; requests in flight are dropped. The receiver cannot
// stall, so nothing ever holds back.
`timescale 1ns / 1ps
`default_nettype none

module drive_mixer_pulse_mapper
   import dmpm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [7:0]      req_forward_or_left,
   input  wire logic signed [7:0]      req_yaw_or_right,
   input  wire logic signed [7:0]      req_strafe_axis,

   output logic                        rsp_valid,
   output logic [11:0]                 rsp_front_left_pulse,
   output logic [11:0]                 rsp_back_left_pulse,
   output logic [11:0]                 rsp_front_right_pulse,
   output logic [11:0]                 rsp_back_right_pulse,

   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration registers.
   logic [MODE_W-1:0]     drive_mode_in;
   logic [MODE_W-1:0]     drive_mode_ff;
   pulse_type             min_pulse_in;
   pulse_type             min_pulse_ff;
   pulse_type             max_pulse_in;
   pulse_type             max_pulse_ff;
   logic [NUM_WHEELS-1:0] reverse_mask_in;
   logic [NUM_WHEELS-1:0] reverse_mask_ff;
   pulse_cfg_type         pulse_cfg;

   // Input register and valid pipeline.
   logic                  accept;
   wheel_type             forward_ff;
   wheel_type             yaw_ff;
   wheel_type             strafe_ff;
   logic                  in_valid_ff;
   logic                  mul_valid_ff;
   logic                  rsp_valid_ff;

   wheel_vec_type         wheels;
   pulse_type             pulses [NUM_WHEELS];

   // Result register.
   pulse_type             rsp_fl_ff;
   pulse_type             rsp_bl_ff;
   pulse_type             rsp_fr_ff;
   pulse_type             rsp_br_ff;

   // The pipeline takes a new transaction every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Software must write registers only when no transaction is in flight; not enforced.
   always_comb begin
      drive_mode_in   = drive_mode_ff;
      min_pulse_in    = min_pulse_ff;
      max_pulse_in    = max_pulse_ff;
      reverse_mask_in = reverse_mask_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DRIVE_MODE:   drive_mode_in   = csr_write_data[MODE_W-1:0];
            CSR_MIN_PULSE:    min_pulse_in    = csr_write_data[PULSE_W-1:0];
            CSR_MAX_PULSE:    max_pulse_in    = csr_write_data[PULSE_W-1:0];
            CSR_REVERSE_MASK: reverse_mask_in = csr_write_data[NUM_WHEELS-1:0];
            default:          drive_mode_in   = drive_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff   <= MODE_TANK;
         min_pulse_ff    <= MIN_PULSE_RESET;
         max_pulse_ff    <= MAX_PULSE_RESET;
         reverse_mask_ff <= '0;
      end else begin
         drive_mode_ff   <= drive_mode_in;
         min_pulse_ff    <= min_pulse_in;
         max_pulse_ff    <= max_pulse_in;
         reverse_mask_ff <= reverse_mask_in;
      end
   end

   assign pulse_cfg.min_pulse = min_pulse_ff;
   assign pulse_cfg.max_pulse = max_pulse_ff;

   // Valid bits follow the data through the three register stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= accept;
         mul_valid_ff <= in_valid_ff;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   // The axis payload is captured only when a transaction is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         forward_ff <= req_forward_or_left;
         yaw_ff     <= req_yaw_or_right;
         strafe_ff  <= req_strafe_axis;
      end
   end

   dmpm_mixer u_mixer (
      .drive_mode      (drive_mode_ff),
      .forward_or_left (forward_ff),
      .yaw_or_right    (yaw_ff),
      .strafe_axis     (strafe_ff),
      .wheels          (wheels)
   );

   // One scaler per wheel; each holds its own multiply stage register.
   for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_wheel
      dmpm_scale u_scale (
         .clock   (clock),
         .wheel   (wheels[i]),
         .reverse (reverse_mask_ff[i]),
         .cfg     (pulse_cfg),
         .pulse   (pulses[i])
      );
   end

   always_ff @(posedge clock) begin
      rsp_fl_ff <= pulses[WHEEL_FL];
      rsp_bl_ff <= pulses[WHEEL_BL];
      rsp_fr_ff <= pulses[WHEEL_FR];
      rsp_br_ff <= pulses[WHEEL_BR];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_front_left_pulse  = rsp_fl_ff;
   assign rsp_back_left_pulse   = rsp_bl_ff;
   assign rsp_front_right_pulse = rsp_fr_ff;
   assign rsp_back_right_pulse  = rsp_br_ff;

   // Every accepted transaction produces its result strobe.
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("accepted transaction did not produce a result");

   // No result strobe appears without a matching accepted transaction.
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result strobe without a matching transaction");

   // Front left pulse stays between the two pulse limits.
   a_fl_in_band : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_front_left_pulse >= min_pulse_ff) && (rsp_front_left_pulse <= max_pulse_ff)) ||
         ((rsp_front_left_pulse <= min_pulse_ff) && (rsp_front_left_pulse >= max_pulse_ff)))
      else $error("front left pulse outside the configured limits");

   // Back right pulse stays between the two pulse limits.
   a_br_in_band : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_back_right_pulse >= min_pulse_ff) && (rsp_back_right_pulse <= max_pulse_ff)) ||
         ((rsp_back_right_pulse <= min_pulse_ff) && (rsp_back_right_pulse >= max_pulse_ff)))
      else $error("back right pulse outside the configured limits");

   // Outside holonomic mode both left wheels see the same value, so with equal
   // reverse bits they must get the same pulse.
   a_left_pair_match : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (drive_mode_ff != MODE_HOLONOMIC) &&
       (reverse_mask_ff[WHEEL_FL] == reverse_mask_ff[WHEEL_BL])) |->
         (rsp_front_left_pulse == rsp_back_left_pulse))
      else $error("left wheel pair differs outside holonomic mode");

endmodule

`default_nettype wire
